@@ rtl/mbm_pkg.sv @@
// Shared types and constants for the master bus mix, gain and meter block.
// Used by mbm_ctrl, mbm_dp and master_bus_mix_gain_meter_unit.
`default_nettype none

package mbm_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int SUM_W      = 27;
  localparam int GAIN_W     = 16;
  localparam int LEN_W      = 13;
  localparam int LEVEL_W    = 23;
  localparam int SQSUM_W    = 60;
  localparam int MAX_BLOCK  = 4096;
  localparam int DIV_STEPS  = SQSUM_W;
  localparam int SQRT_STEPS = SQSUM_W / 2;
  localparam int STEP_W     = 6;

  localparam int IN_DATA_W  = 2 * SAMPLE_W;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 2;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CFG_ADDR_W-1:0] REG_MASTER_GAIN  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_LENGTH = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 13'd512;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACC,
    OP_MUL_L,
    OP_MUL_R,
    OP_RND_R,
    OP_SQ_R,
    OP_ACC_SQ,
    OP_DIV,
    OP_SQRT,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/master_bus_mix_gain_meter_unit.sv @@
// Top level of the stereo master bus mixer with gain, clip flag and block meters.
// Depends on mbm_pkg, mbm_ctrl and mbm_dp.
//
// Usage: send one transfer per track on the s_axis channel, left and right
// samples in tdata, tlast high on the final track of a frame. Tracks that are
// not last are summed one per cycle, back to back. A last track starts the
// frame sequence and the input stalls until it completes: gain multiply and
// rounding for both channels, then squaring into the meters, and then the
// emit step loads the frame into the result register on m_axis. On the frame
// that ends a metering block, a restoring divide by twice the block length
// and a square root run between the squaring and the emit step. One result
// register sits on m_axis: the next frame's tracks are accepted while a
// result waits, and only the final step of the next frame holds until the
// receiver takes it. Reset clears the sums, meters and frame count and loads
// master gain 4096 and block length 512. The config port writes one register
// per cycle with cfg_we high.
`default_nettype none

module master_bus_mix_gain_meter_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mbm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [mbm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // track_left, track_right
  input  logic [mbm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // mix_left, mix_right, peak_level, rms_level, zero fill
  output logic [mbm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // clipped, meter_valid
  output logic [mbm_pkg::OUT_USER_W-1:0]      m_axis_tuser
);

  mbm_pkg::cmd_t                          cmd;
  mbm_pkg::status_t                       status;
  logic signed [mbm_pkg::SAMPLE_W-1:0]    mix_left;
  logic signed [mbm_pkg::SAMPLE_W-1:0]    mix_right;
  logic                                   clipped;
  logic                                   meter_valid;
  logic [mbm_pkg::LEVEL_W-1:0]            peak_level;
  logic [mbm_pkg::LEVEL_W-1:0]            rms_level;

  mbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mbm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .in_left     ($signed(s_axis_tdata[mbm_pkg::SAMPLE_W-1:0])),
    .in_right    ($signed(s_axis_tdata[mbm_pkg::IN_DATA_W-1:mbm_pkg::SAMPLE_W])),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .mix_left    (mix_left),
    .mix_right   (mix_right),
    .clipped     (clipped),
    .meter_valid (meter_valid),
    .peak_level  (peak_level),
    .rms_level   (rms_level)
  );

  assign m_axis_tdata = {
    {(mbm_pkg::OUT_DATA_W - 2 * mbm_pkg::SAMPLE_W - 2 * mbm_pkg::LEVEL_W){1'b0}},
    rms_level, peak_level, mix_right, mix_left
  };
  assign m_axis_tuser = {meter_valid, clipped};

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mbm_pkg::OP_EMIT) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten while stalled");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (cmd.op == mbm_pkg::OP_NONE || cmd.op == mbm_pkg::OP_ACC))
    else $error("input ready during frame processing");

  a_meter_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[1]) |-> (peak_level == '0 && rms_level == '0))
    else $error("meter levels nonzero outside block end");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.op == mbm_pkg::OP_EMIT))
    else $error("result valid without emit step");

endmodule

`default_nettype wire

@@ rtl/mbm_ctrl.sv @@
// Sequencer for the mix bus: accepts tracks, steps the datapath through gain,
// metering, block-end divide and square root, then hands off the result.
// Depends on mbm_pkg.
`default_nettype none

module mbm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  input  mbm_pkg::status_t status,
  output mbm_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_L,
    S_MUL_R,
    S_RND_R,
    S_SQ_R,
    S_ACC_SQ,
    S_DIV,
    S_SQRT,
    S_EMIT
  } state_t;

  state_t                      state;
  logic [mbm_pkg::STEP_W-1:0]  cnt;

  always_comb begin
    in_ready = (state == S_IDLE);
    cmd.op   = mbm_pkg::OP_NONE;
    unique case (state)
      S_IDLE:   if (in_valid) cmd.op = mbm_pkg::OP_ACC;
      S_MUL_L:  cmd.op = mbm_pkg::OP_MUL_L;
      S_MUL_R:  cmd.op = mbm_pkg::OP_MUL_R;
      S_RND_R:  cmd.op = mbm_pkg::OP_RND_R;
      S_SQ_R:   cmd.op = mbm_pkg::OP_SQ_R;
      S_ACC_SQ: cmd.op = mbm_pkg::OP_ACC_SQ;
      S_DIV:    cmd.op = mbm_pkg::OP_DIV;
      S_SQRT:   cmd.op = mbm_pkg::OP_SQRT;
      S_EMIT:   if (status.out_free) cmd.op = mbm_pkg::OP_EMIT;
      default:  cmd.op = mbm_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE:   if (in_valid && in_last) state <= S_MUL_L;
        S_MUL_L:  state <= S_MUL_R;
        S_MUL_R:  state <= S_RND_R;
        S_RND_R:  state <= S_SQ_R;
        S_SQ_R:   state <= S_ACC_SQ;
        S_ACC_SQ: begin
          cnt   <= '0;
          state <= status.done ? S_DIV : S_EMIT;
        end
        S_DIV: begin
          if (cnt == mbm_pkg::STEP_W'(mbm_pkg::DIV_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQRT: begin
          if (cnt == mbm_pkg::STEP_W'(mbm_pkg::SQRT_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_EMIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_EMIT:   if (status.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/mbm_dp.sv @@
// Datapath for the mix bus: accumulators, gain multiplier, meters, restoring
// divider, digit-by-digit square root, config and output registers.
// Depends on mbm_pkg; driven by mbm_ctrl commands.
`default_nettype none

module mbm_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [mbm_pkg::CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [mbm_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic signed [mbm_pkg::SAMPLE_W-1:0]    in_left,
  input  logic signed [mbm_pkg::SAMPLE_W-1:0]    in_right,
  input  mbm_pkg::cmd_t                          cmd,
  output mbm_pkg::status_t                       status,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic signed [mbm_pkg::SAMPLE_W-1:0]    mix_left,
  output logic signed [mbm_pkg::SAMPLE_W-1:0]    mix_right,
  output logic                                   clipped,
  output logic                                   meter_valid,
  output logic [mbm_pkg::LEVEL_W-1:0]            peak_level,
  output logic [mbm_pkg::LEVEL_W-1:0]            rms_level
);

  localparam int PROD_W = mbm_pkg::SUM_W + mbm_pkg::GAIN_W + 1;
  localparam int SQ_W   = 2 * mbm_pkg::SAMPLE_W;
  localparam int DVS_W  = mbm_pkg::LEN_W + 1;
  localparam int ROOT_W = mbm_pkg::SQRT_STEPS;
  localparam int SREM_W = ROOT_W + 2;

  logic [mbm_pkg::GAIN_W-1:0]              gain;
  logic [mbm_pkg::LEN_W-1:0]               blen;
  logic signed [mbm_pkg::SUM_W-1:0]        left_sum;
  logic signed [mbm_pkg::SUM_W-1:0]        right_sum;
  logic signed [PROD_W-1:0]                prod;
  logic signed [mbm_pkg::SAMPLE_W-1:0]     ls;
  logic signed [mbm_pkg::SAMPLE_W-1:0]     rs;
  logic                                    clip_l;
  logic                                    clip_r;
  logic [SQ_W-1:0]                         sq;
  logic [mbm_pkg::SQSUM_W-1:0]             sq_sum;
  logic [mbm_pkg::LEVEL_W-1:0]             peak;
  logic [mbm_pkg::LEN_W-1:0]               fc;
  logic                                    done;
  logic [mbm_pkg::LEN_W-1:0]               rem;
  logic [mbm_pkg::SQSUM_W-1:0]             dvd;
  logic [SREM_W-1:0]                       srem;
  logic [ROOT_W-1:0]                       root;

  logic [mbm_pkg::LEN_W-1:0]               len_eff;
  logic [mbm_pkg::LEN_W-1:0]               fc_inc;
  logic [DVS_W-1:0]                        divisor;
  logic [DVS_W-1:0]                        rsh;
  logic [DVS_W-1:0]                        rdiff;
  logic [SREM_W+1:0]                       ssh;
  logic [SREM_W+1:0]                       trial;
  logic [SREM_W+1:0]                       sdiff;
  logic [mbm_pkg::SAMPLE_W-1:0]            abs_l;
  logic [mbm_pkg::SAMPLE_W-1:0]            abs_r;
  logic [mbm_pkg::LEVEL_W-1:0]             pk_l;
  logic [mbm_pkg::LEVEL_W-1:0]             pk_r;
  logic [mbm_pkg::SQSUM_W-1:0]             sq_sum_next;
  logic [mbm_pkg::LEVEL_W-1:0]             rms_sat;
  logic [mbm_pkg::SAMPLE_W:0]              rnd_out;

  function automatic logic signed [mbm_pkg::SUM_W-1:0] acc_sat(
    input logic signed [mbm_pkg::SUM_W-1:0]    s,
    input logic signed [mbm_pkg::SAMPLE_W-1:0] x
  );
    logic [mbm_pkg::SUM_W:0] t;
    t = {s[mbm_pkg::SUM_W-1], s}
      + {{(mbm_pkg::SUM_W - mbm_pkg::SAMPLE_W + 1){x[mbm_pkg::SAMPLE_W-1]}}, x};
    if (t[mbm_pkg::SUM_W] != t[mbm_pkg::SUM_W-1]) begin
      acc_sat = t[mbm_pkg::SUM_W] ? {1'b1, {(mbm_pkg::SUM_W-1){1'b0}}}
                                  : {1'b0, {(mbm_pkg::SUM_W-1){1'b1}}};
    end else begin
      acc_sat = t[mbm_pkg::SUM_W-1:0];
    end
  endfunction

  // Returns {clip, saturated sample}.
  function automatic logic [mbm_pkg::SAMPLE_W:0] round_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] pr;
    logic [PROD_W-13:0]       q;
    pr = p + PROD_W'(2048);
    q  = pr[PROD_W-1:12];
    if (q[PROD_W-13:mbm_pkg::SAMPLE_W-1] !=
        {(PROD_W - 12 - mbm_pkg::SAMPLE_W + 1){q[mbm_pkg::SAMPLE_W-1]}}) begin
      round_sat = q[PROD_W-13] ? {1'b1, 1'b1, {(mbm_pkg::SAMPLE_W-1){1'b0}}}
                               : {1'b1, 1'b0, {(mbm_pkg::SAMPLE_W-1){1'b1}}};
    end else begin
      round_sat = {1'b0, q[mbm_pkg::SAMPLE_W-1:0]};
    end
  endfunction

  function automatic logic [mbm_pkg::SAMPLE_W-1:0] abs24(
    input logic signed [mbm_pkg::SAMPLE_W-1:0] s
  );
    abs24 = s[mbm_pkg::SAMPLE_W-1] ? (~s) + 1'b1 : s;
  endfunction

  function automatic logic [mbm_pkg::LEVEL_W-1:0] peak_sat(
    input logic [mbm_pkg::SAMPLE_W-1:0] a
  );
    peak_sat = a[mbm_pkg::SAMPLE_W-1] ? {mbm_pkg::LEVEL_W{1'b1}}
                                      : a[mbm_pkg::LEVEL_W-1:0];
  endfunction

  always_comb begin
    if (blen == '0) begin
      len_eff = mbm_pkg::LEN_W'(1);
    end else if (blen > mbm_pkg::LEN_W'(mbm_pkg::MAX_BLOCK)) begin
      len_eff = mbm_pkg::LEN_W'(mbm_pkg::MAX_BLOCK);
    end else begin
      len_eff = blen;
    end
    fc_inc      = fc + 1'b1;
    divisor     = {len_eff, 1'b0};
    rsh         = {rem, dvd[mbm_pkg::SQSUM_W-1]};
    rdiff       = rsh - divisor;
    ssh         = {srem, dvd[mbm_pkg::SQSUM_W-1 -: 2]};
    trial       = {2'b00, root, 2'b01};
    sdiff       = ssh - trial;
    abs_l       = abs24(ls);
    abs_r       = abs24(rs);
    pk_l        = peak_sat(abs_l);
    pk_r        = peak_sat(abs_r);
    sq_sum_next = sq_sum + mbm_pkg::SQSUM_W'(sq);
    rms_sat     = (|root[ROOT_W-1:mbm_pkg::LEVEL_W]) ? {mbm_pkg::LEVEL_W{1'b1}}
                                                    : root[mbm_pkg::LEVEL_W-1:0];
    rnd_out     = round_sat(prod);
    status.done     = done;
    status.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= mbm_pkg::GAIN_RESET;
      blen      <= mbm_pkg::LEN_RESET;
      left_sum  <= '0;
      right_sum <= '0;
      sq_sum    <= '0;
      peak      <= '0;
      fc        <= '0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          mbm_pkg::REG_MASTER_GAIN:  gain <= cfg_data;
          mbm_pkg::REG_BLOCK_LENGTH: blen <= cfg_data[mbm_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && cmd.op != mbm_pkg::OP_EMIT) out_valid <= 1'b0;

      unique case (cmd.op)
        mbm_pkg::OP_ACC: begin
          left_sum  <= acc_sat(left_sum, in_left);
          right_sum <= acc_sat(right_sum, in_right);
        end
        mbm_pkg::OP_MUL_L: begin
          prod <= left_sum * $signed({1'b0, gain});
        end
        mbm_pkg::OP_MUL_R: begin
          prod      <= right_sum * $signed({1'b0, gain});
          ls        <= rnd_out[mbm_pkg::SAMPLE_W-1:0];
          clip_l    <= rnd_out[mbm_pkg::SAMPLE_W];
          left_sum  <= '0;
          right_sum <= '0;
        end
        mbm_pkg::OP_RND_R: begin
          rs     <= rnd_out[mbm_pkg::SAMPLE_W-1:0];
          clip_r <= rnd_out[mbm_pkg::SAMPLE_W];
          sq     <= abs_l * abs_l;
          if (pk_l > peak) peak <= pk_l;
        end
        mbm_pkg::OP_SQ_R: begin
          sq_sum <= sq_sum_next;
          sq     <= abs_r * abs_r;
          if (pk_r > peak) peak <= pk_r;
          done   <= (fc_inc >= len_eff);
          fc     <= (fc_inc >= len_eff) ? '0 : fc_inc;
        end
        mbm_pkg::OP_ACC_SQ: begin
          sq_sum <= sq_sum_next;
          dvd    <= sq_sum_next;
          rem    <= '0;
          srem   <= '0;
          root   <= '0;
        end
        mbm_pkg::OP_DIV: begin
          if (rsh >= divisor) begin
            rem <= rdiff[mbm_pkg::LEN_W-1:0];
            dvd <= {dvd[mbm_pkg::SQSUM_W-2:0], 1'b1};
          end else begin
            rem <= rsh[mbm_pkg::LEN_W-1:0];
            dvd <= {dvd[mbm_pkg::SQSUM_W-2:0], 1'b0};
          end
        end
        mbm_pkg::OP_SQRT: begin
          dvd <= {dvd[mbm_pkg::SQSUM_W-3:0], 2'b00};
          if (ssh >= trial) begin
            srem <= sdiff[SREM_W-1:0];
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            srem <= ssh[SREM_W-1:0];
            root <= {root[ROOT_W-2:0], 1'b0};
          end
        end
        mbm_pkg::OP_EMIT: begin
          out_valid   <= 1'b1;
          mix_left    <= ls;
          mix_right   <= rs;
          clipped     <= clip_l | clip_r;
          meter_valid <= done;
          peak_level  <= done ? peak : '0;
          rms_level   <= done ? rms_sat : '0;
          if (done) begin
            peak   <= '0;
            sq_sum <= '0;
            done   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ verif/master_bus_mix_gain_meter_unit_tb.sv @@
// Self-checking testbench for master_bus_mix_gain_meter_unit: drives track transfers,
// predicts every mixed frame with its gain, clip flag and block meters, checks each result.
// Depends on mbm_pkg and the RTL of master_bus_mix_gain_meter_unit.
`default_nettype none

module master_bus_mix_gain_meter_unit_tb;
  import mbm_pkg::*;

  localparam longint SUM_HI = 67108863;
  localparam longint SUM_LO = -67108864;
  localparam longint OUT_HI = 8388607;
  localparam longint OUT_LO = -8388608;
  localparam int     RIGHT_LSB = SAMPLE_W;
  localparam int     PEAK_LSB  = 2 * SAMPLE_W;
  localparam int     RMS_LSB   = 2 * SAMPLE_W + LEVEL_W;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       last_track;
  } track_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] mix_left;
    logic signed [SAMPLE_W-1:0] mix_right;
    logic                       clipped;
    logic                       meter_valid;
    logic [LEVEL_W-1:0]         peak_level;
    logic [LEVEL_W-1:0]         rms_level;
  } frame_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr = REG_MASTER_GAIN;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
  logic                    s_axis_tlast = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic [OUT_USER_W-1:0]   m_axis_tuser;

  master_bus_mix_gain_meter_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  track_t             track_queue[$];
  frame_t             frames_due[$];
  logic               track_taken = 1'b0;
  int                 idle_pct = 35;
  int                 errors = 0;
  int                 tracks_sent = 0;
  int                 frames_checked = 0;
  int                 meter_blocks = 0;
  int                 clip_frames = 0;

  // mirror of the mixer state and registers
  logic [GAIN_W-1:0]  gain_q412 = GAIN_RESET;
  logic [LEN_W-1:0]   block_len_reg = LEN_RESET;
  longint             acc_left = 0;
  longint             acc_right = 0;
  logic [LEN_W-1:0]   frames_in_block = '0;
  longint unsigned    peak_hold = 0;
  longint unsigned    sq_total = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint scale(longint sum);
    longint p;
    p = sum * longint'(gain_q412) + 2048;
    return p >>> 12;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic void take_track(track_t t);
    longint          mix[2];
    longint          sat_mix[2];
    longint unsigned mag, rms;
    int unsigned     len;
    frame_t          f;
    acc_left = clamp(acc_left + longint'(t.left_in), SUM_LO, SUM_HI);
    acc_right = clamp(acc_right + longint'(t.right_in), SUM_LO, SUM_HI);
    if (!t.last_track) return;
    mix[0] = scale(acc_left);
    mix[1] = scale(acc_right);
    acc_left = 0;
    acc_right = 0;
    f.clipped = 1'b0;
    for (int c = 0; c < 2; c++) begin
      sat_mix[c] = clamp(mix[c], OUT_LO, OUT_HI);
      if (sat_mix[c] != mix[c]) f.clipped = 1'b1;
      mag = (sat_mix[c] < 0) ? -sat_mix[c] : sat_mix[c];
      sq_total += mag * mag;
      if (mag > OUT_HI) mag = OUT_HI;
      if (mag > peak_hold) peak_hold = mag;
    end
    f.mix_left = SAMPLE_W'(sat_mix[0]);
    f.mix_right = SAMPLE_W'(sat_mix[1]);
    len = 32'(block_len_reg);
    if (len < 1) len = 1;
    if (len > MAX_BLOCK) len = MAX_BLOCK;
    frames_in_block = frames_in_block + 1'b1;
    f.meter_valid = (frames_in_block >= len);
    f.peak_level = '0;
    f.rms_level = '0;
    if (f.meter_valid) begin
      rms = root_floor(sq_total / (2 * longint'(len)));
      if (rms > OUT_HI) rms = OUT_HI;
      f.peak_level = LEVEL_W'(peak_hold);
      f.rms_level = LEVEL_W'(rms);
      frames_in_block = '0;
      peak_hold = 0;
      sq_total = 0;
    end
    frames_due = {frames_due, f};
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // driver: tracks at the falling edge, receiver ready at random
  always @(negedge clk) begin : drive
    track_t t;
    if (!rst && (!s_axis_tvalid || track_taken)) begin
      if (track_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        t = track_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {t.right_in, t.left_in};
        s_axis_tlast <= t.last_track;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= !rst && ($urandom_range(99) >= idle_pct);
  end

  // monitor: results first, then the track taken on this edge
  always @(posedge clk) begin : watch
    frame_t want;
    track_t t;
    track_taken <= s_axis_tvalid && s_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected frame, expected none, actual tdata %h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = frames_due.pop_front();
        check_field("mix_left", want.mix_left, $signed(m_axis_tdata[RIGHT_LSB-1:0]));
        check_field("mix_right", want.mix_right,
                    $signed(m_axis_tdata[PEAK_LSB-1:RIGHT_LSB]));
        check_field("clipped", want.clipped, m_axis_tuser[0]);
        check_field("meter_valid", want.meter_valid, m_axis_tuser[1]);
        check_field("peak_level", want.peak_level, m_axis_tdata[RMS_LSB-1:PEAK_LSB]);
        check_field("rms_level", want.rms_level,
                    m_axis_tdata[RMS_LSB+LEVEL_W-1:RMS_LSB]);
        frames_checked++;
        if (want.meter_valid) meter_blocks++;
        if (want.clipped) clip_frames++;
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      t.left_in = s_axis_tdata[RIGHT_LSB-1:0];
      t.right_in = s_axis_tdata[IN_DATA_W-1:RIGHT_LSB];
      t.last_track = s_axis_tlast;
      take_track(t);
      tracks_sent++;
    end
  end

  task automatic push_track(longint l, longint r, logic last);
    track_t t;
    t.left_in = SAMPLE_W'(l);
    t.right_in = SAMPLE_W'(r);
    t.last_track = last;
    track_queue = {track_queue, t};
  endtask

  function automatic longint pick_sample();
    case ($urandom_range(9))
      0: return OUT_HI;
      1: return OUT_LO;
      2, 3, 4, 5: return longint'($urandom_range(2097151)) - 1048576;
      default: return longint'($signed(24'($urandom)));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MASTER_GAIN) gain_q412 = val;
    else block_len_reg = val[LEN_W-1:0];
  endtask

  task automatic drain();
    while (track_queue.size() != 0 || s_axis_tvalid || frames_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] gain, logic [CFG_DATA_W-1:0] len,
                           int count);
    int queued, n;
    write_reg(REG_MASTER_GAIN, gain);
    write_reg(REG_BLOCK_LENGTH, len);
    queued = 0;
    while (queued < count) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) push_track(pick_sample(), pick_sample(), i == n - 1);
      queued += n;
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: full-scale frame, accumulator saturation, silence
    push_track(OUT_HI, OUT_LO, 1'b1);
    for (int i = 0; i < 9; i++) push_track(OUT_LO, OUT_HI, 1'b0);
    push_track(OUT_LO, OUT_HI, 1'b1);
    push_track(0, 0, 1'b1);
    drain();

    // half gain: rounding of odd sums in both directions
    write_reg(REG_MASTER_GAIN, 16'd2048);
    write_reg(REG_BLOCK_LENGTH, 16'd8);
    push_track(1, -1, 1'b1);
    push_track(3, -3, 1'b1);
    push_track(5, -5, 1'b1);
    drain();

    // shorten the block under the running count, maximum gain clips
    write_reg(REG_MASTER_GAIN, 16'hFFFF);
    write_reg(REG_BLOCK_LENGTH, 16'd2);
    push_track(OUT_HI, OUT_LO, 1'b1);
    drain();

    // one-frame block at negative full scale saturates peak and RMS
    write_reg(REG_MASTER_GAIN, GAIN_RESET);
    write_reg(REG_BLOCK_LENGTH, 16'd1);
    push_track(OUT_LO, OUT_LO, 1'b1);
    drain();

    // zero length and zero gain
    write_reg(REG_MASTER_GAIN, 16'd0);
    write_reg(REG_BLOCK_LENGTH, 16'd0);
    push_track(OUT_HI, OUT_HI, 1'b1);
    drain();

    idle_pct = 0;
    run_phase(GAIN_RESET, 16'd4, 110);
    idle_pct = 35;
    run_phase(16'hFFFF, 16'd1, 100);
    run_phase(16'd0, 16'd3, 60);
    run_phase(16'($urandom), 16'd0, 100);
    run_phase(16'($urandom_range(1024, 8192)), 16'hFFFF, 100);
    run_phase(16'($urandom_range(1024, 8192)), 16'd4096, 60);
    run_phase(16'($urandom), 16'd2, 120);
    run_phase(16'd2048, 16'd7, 150);
    run_phase(16'($urandom_range(2048, 6144)), 16'd5, 50);

    drain();
    repeat (120) @(posedge clk);
    $display("Summary: %0d tracks mixed into %0d frames, %0d meter blocks, %0d clipped",
             tracks_sent, frames_checked, meter_blocks, clip_frames);
    $display("Summary: gains 0 to 65535, block lengths 0 to 8191, saturation and rounding");
    if (errors == 0) begin
      $display("master_bus_mix_gain_meter_unit_tb: PASS");
    end else begin
      $display("master_bus_mix_gain_meter_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #4800000;
    $display("Timeout waiting for transfers");
    $display("master_bus_mix_gain_meter_unit_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/mbm_pkg.sv
rtl/mbm_ctrl.sv
rtl/mbm_dp.sv
rtl/master_bus_mix_gain_meter_unit.sv
verif/master_bus_mix_gain_meter_unit_tb.sv
